// File: hdl/mtep_pkg.sv
// Package: shared types, codes and constants of the MIDI track event parser.
`timescale 1ns / 1ps
package mtep_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_Q = 2'd1;
    localparam logic [1:0] CFG_INIT_TEMPO  = 2'd2;

    localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;
    localparam logic [14:0] TPQ_RST         = 15'd96;
    localparam logic [23:0] DEFAULT_TEMPO   = 24'd500000;
    localparam logic [19:0] USEC_PER_SEC    = 20'd1000000;

    // Parse phases
    localparam logic [3:0] PH_DELTA  = 4'd0;
    localparam logic [3:0] PH_STATUS = 4'd1;
    localparam logic [3:0] PH_DATA1  = 4'd2;
    localparam logic [3:0] PH_DATA2  = 4'd3;
    localparam logic [3:0] PH_SYSLEN = 4'd4;
    localparam logic [3:0] PH_MTYPE  = 4'd5;
    localparam logic [3:0] PH_MLEN   = 4'd6;
    localparam logic [3:0] PH_MDATA  = 4'd7;
    localparam logic [3:0] PH_SKIP   = 4'd8;

    // Event kinds
    localparam logic [2:0] EV_CHANNEL   = 3'd0;
    localparam logic [2:0] EV_TEMPO     = 3'd1;
    localparam logic [2:0] EV_SYSEX     = 3'd2;
    localparam logic [2:0] EV_END       = 3'd3;
    localparam logic [2:0] EV_EXHAUSTED = 3'd4;

    localparam logic [7:0]  VL_MASK      = 8'h7F;
    localparam logic [31:0] VL_LIMIT     = 32'h0100_0000;
    localparam logic [7:0]  META_STATUS  = 8'hFF;
    localparam logic [7:0]  SYSEX_STATUS = 8'hF0;
    localparam logic [7:0]  SYSEX_ESCAPE = 8'hF7;
    localparam logic [7:0]  META_END     = 8'h2F;
    localparam logic [7:0]  META_TEMPO   = 8'h51;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] tick_time;
        logic [31:0] sample_time;
        logic [23:0] new_tempo;
        logic [31:0] sysex_length;
        logic        last;
    } out_beat_t;

    // Event found by the parser, before it is time stamped
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [23:0] tempo;
        logic [31:0] len;
    } event_t;

    // Segment state handed from the parser to the time stamp unit
    typedef struct packed {
        logic [31:0] seg_tick;
        logic [31:0] seg_sample;
        logic [23:0] seg_tempo;
        logic [31:0] tick_count;
    } seg_info_t;

endpackage

// File: hdl/mtep_parser.sv
// Byte-level track parser: phase machine, running status and tempo segment state.
`timescale 1ns / 1ps
module mtep_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  mtep_pkg::in_beat_t   beat,
    input  logic                 tempo_wr,
    input  logic [23:0]          tempo_val,
    input  logic                 seg_load,
    input  logic [31:0]          seg_sample_in,
    output logic                 main_valid,
    output logic                 exh_valid,
    output mtep_pkg::event_t     main_event,
    output mtep_pkg::seg_info_t  seg_info
);

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] delta_reg, delta_next;
    logic [31:0] tick_reg, tick_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  current_reg, current_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  meta_reg, meta_next;
    logic [23:0] tcap_reg, tcap_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic        ended_reg, ended_next;
    logic        pend_reg, pend_next;
    logic [31:0] seg_tick_reg;
    logic [31:0] seg_sample_reg;
    logic [23:0] seg_tempo_reg;

    logic [7:0]  b;
    logic [31:0] vl_acc, vl_val;
    logic        vl_done, as_delta, one_byte_cur, one_byte_run;

    assign b            = beat.data_byte;
    assign vl_acc       = {delta_reg[24:0], b[6:0] & mtep_pkg::VL_MASK[6:0]};
    assign vl_done      = ~b[7];
    assign vl_val       = (vl_acc > mtep_pkg::VL_LIMIT) ? {24'd0, vl_acc[7:0]} : vl_acc;
    assign one_byte_cur = (current_reg[7:4] == 4'hC) || (current_reg[7:4] == 4'hD);
    assign one_byte_run = (running_reg[7:4] == 4'hC) || (running_reg[7:4] == 4'hD);

    always_comb begin
        phase_next   = phase_reg;
        delta_next   = delta_reg;
        tick_next    = tick_reg;
        running_next = running_reg;
        current_next = current_reg;
        held_next    = held_reg;
        skip_next    = skip_reg;
        meta_next    = meta_reg;
        tcap_next    = tcap_reg;
        cidx_next    = cidx_reg;
        ended_next   = ended_reg;
        pend_next    = 1'b0;
        main_valid   = 1'b0;
        exh_valid    = 1'b0;
        main_event   = '0;
        as_delta     = 1'b0;
        if (!ended_reg) begin
            unique case (phase_reg)
                mtep_pkg::PH_STATUS: begin
                    if (b[7]) begin
                        current_next = b;
                        if (b < mtep_pkg::SYSEX_STATUS) begin
                            running_next = b;
                            phase_next   = mtep_pkg::PH_DATA1;
                        end else if (b == mtep_pkg::SYSEX_STATUS ||
                                     b == mtep_pkg::SYSEX_ESCAPE) begin
                            phase_next = mtep_pkg::PH_SYSLEN;
                        end else if (b == mtep_pkg::META_STATUS) begin
                            phase_next = mtep_pkg::PH_MTYPE;
                        end else begin
                            skip_next  = 32'd1;
                            phase_next = mtep_pkg::PH_SKIP;
                        end
                    end else if (running_reg[7]) begin
                        current_next = running_reg;
                        if (one_byte_run) begin
                            main_valid        = 1'b1;
                            main_event.kind   = mtep_pkg::EV_CHANNEL;
                            main_event.status = running_reg;
                            main_event.d1     = b;
                            phase_next        = mtep_pkg::PH_DELTA;
                        end else begin
                            held_next  = b;
                            phase_next = mtep_pkg::PH_DATA2;
                        end
                    end else begin
                        current_next = running_reg;
                        as_delta     = 1'b1;
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    if (one_byte_cur) begin
                        main_valid        = 1'b1;
                        main_event.kind   = mtep_pkg::EV_CHANNEL;
                        main_event.status = current_reg;
                        main_event.d1     = b;
                        phase_next        = mtep_pkg::PH_DELTA;
                    end else begin
                        held_next  = b;
                        phase_next = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    main_valid        = 1'b1;
                    main_event.kind   = mtep_pkg::EV_CHANNEL;
                    main_event.status = current_reg;
                    main_event.d1     = held_reg;
                    main_event.d2     = b;
                    phase_next        = mtep_pkg::PH_DELTA;
                end
                mtep_pkg::PH_SYSLEN: begin
                    if (vl_done) begin
                        delta_next        = '0;
                        main_valid        = 1'b1;
                        main_event.kind   = mtep_pkg::EV_SYSEX;
                        main_event.status = current_reg;
                        main_event.len    = vl_val;
                        skip_next         = vl_val;
                        phase_next = (vl_val != '0) ? mtep_pkg::PH_SKIP : mtep_pkg::PH_DELTA;
                    end else begin
                        delta_next = vl_acc;
                    end
                end
                mtep_pkg::PH_MTYPE: begin
                    meta_next = b;
                    if (b == mtep_pkg::META_END) begin
                        main_valid        = 1'b1;
                        main_event.kind   = mtep_pkg::EV_END;
                        main_event.status = mtep_pkg::META_STATUS;
                        ended_next        = 1'b1;
                    end else begin
                        phase_next = mtep_pkg::PH_MLEN;
                    end
                end
                mtep_pkg::PH_MLEN: begin
                    if (vl_done) begin
                        delta_next = '0;
                        skip_next  = vl_val;
                        cidx_next  = '0;
                        tcap_next  = '0;
                        phase_next = (vl_val != '0) ? mtep_pkg::PH_MDATA : mtep_pkg::PH_DELTA;
                    end else begin
                        delta_next = vl_acc;
                    end
                end
                mtep_pkg::PH_MDATA: begin
                    if (meta_reg == mtep_pkg::META_TEMPO && cidx_reg != 2'd3) begin
                        tcap_next = {tcap_reg[15:0], b};
                        cidx_next = cidx_reg + 2'd1;
                        if (cidx_reg == 2'd2) begin
                            pend_next         = 1'b1;
                            main_valid        = 1'b1;
                            main_event.kind   = mtep_pkg::EV_TEMPO;
                            main_event.status = mtep_pkg::META_STATUS;
                            main_event.tempo  = {tcap_reg[15:0], b};
                        end
                    end
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (skip_reg <= 32'd1) begin
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_SKIP: begin
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (skip_reg <= 32'd1) begin
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                end
                default: begin
                    as_delta = 1'b1;
                end
            endcase
            if (as_delta) begin
                phase_next = mtep_pkg::PH_DELTA;
                if (vl_done) begin
                    tick_next  = tick_reg + vl_val;
                    delta_next = '0;
                    phase_next = mtep_pkg::PH_STATUS;
                end else begin
                    delta_next = vl_acc;
                end
            end
            if (beat.last_byte && !ended_next) begin
                exh_valid  = 1'b1;
                ended_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mtep_pkg::PH_DELTA;
            delta_reg      <= '0;
            tick_reg       <= '0;
            running_reg    <= '0;
            current_reg    <= '0;
            held_reg       <= '0;
            skip_reg       <= '0;
            meta_reg       <= '0;
            tcap_reg       <= '0;
            cidx_reg       <= '0;
            ended_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            seg_tick_reg   <= '0;
            seg_sample_reg <= '0;
            seg_tempo_reg  <= mtep_pkg::DEFAULT_TEMPO;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                delta_reg   <= delta_next;
                tick_reg    <= tick_next;
                running_reg <= running_next;
                current_reg <= current_next;
                held_reg    <= held_next;
                skip_reg    <= skip_next;
                meta_reg    <= meta_next;
                tcap_reg    <= tcap_next;
                cidx_reg    <= cidx_next;
                ended_reg   <= ended_next;
                pend_reg    <= pend_next;
            end
            // The new segment opens once the tempo event has its time stamp.
            if (seg_load && pend_reg) begin
                seg_tick_reg   <= tick_reg;
                seg_sample_reg <= seg_sample_in;
                seg_tempo_reg  <= tcap_reg;
                pend_reg       <= 1'b0;
            end
            if (tempo_wr) begin
                seg_tempo_reg <= tempo_val;
            end
        end
    end

    assign seg_info.seg_tick   = seg_tick_reg;
    assign seg_info.seg_sample = seg_sample_reg;
    assign seg_info.seg_tempo  = seg_tempo_reg;
    assign seg_info.tick_count = tick_reg;

endmodule

// File: hdl/mtep_stamp.sv
// Iterative time stamp unit: shift-add multiply and restoring divide on one adder.
`timescale 1ns / 1ps
module mtep_stamp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  mtep_pkg::seg_info_t  seg,
    input  logic [17:0]          sample_rate,
    input  logic [14:0]          ticks_per_q,
    output logic                 done,
    output logic [31:0]          sample
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [41:0] m_reg;
    logic [34:0] d_reg;
    logic [42:0] acc_reg, acc_next;
    logic [31:0] mq_reg, mq_next;
    logic [73:0] dv_reg, dv_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] sample_reg;
    logic        done_reg;

    logic [43:0] alu_a, alu_b;
    logic        alu_sub;
    logic [44:0] alu_res;
    logic [35:0] r2;
    logic        ge;
    logic [14:0] tpq_eff;

    assign tpq_eff = (ticks_per_q == '0) ? 15'd1 : ticks_per_q;
    assign r2      = {rem_reg, dv_reg[73]};

    // The one adder shared by the multiply and divide steps
    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_a   = {8'd0, r2};
            alu_b   = {9'd0, d_reg};
            alu_sub = 1'b1;
        end else begin
            alu_a   = {1'b0, acc_reg};
            alu_b   = {2'd0, m_reg};
            alu_sub = 1'b0;
        end
    end

    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {44'd0, alu_sub};
    assign ge      = alu_res[44];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mq_next    = mq_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                acc_next   = '0;
                mq_next    = seg.tick_count - seg.seg_tick;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mq_reg[0]) begin
                    acc_next = {1'b0, alu_res[42:1]};
                    mq_next  = {alu_res[0], mq_reg[31:1]};
                end else begin
                    acc_next = {1'b0, acc_reg[42:1]};
                    mq_next  = {acc_reg[0], mq_reg[31:1]};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 7'd0) begin
                    // Product is formed; load the dividend and clear the remainder and quotient.
                    dv_next  = {acc_reg[41:0], mq_reg};
                    rem_next = '0;
                    q_next   = '0;
                    cnt_next = 7'd1;
                end else begin
                    rem_next = ge ? alu_res[34:0] : r2[34:0];
                    q_next   = {q_reg[30:0], ge};
                    dv_next  = {dv_reg[72:0], 1'b0};
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd74) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        mq_reg  <= mq_next;
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (state_reg == ST_PREP) begin
            m_reg <= {24'd0, sample_rate} * {18'd0, seg.seg_tempo};
            d_reg <= {15'd0, mtep_pkg::USEC_PER_SEC} * {20'd0, tpq_eff};
        end
        if (state_reg == ST_SUM) begin
            sample_reg <= seg.seg_sample + q_reg;
        end
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

// File: hdl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: configuration, sequencing and result register.
`timescale 1ns / 1ps
// The block takes one byte of a standard MIDI file track per input beat and gives one
// result beat per event: channel messages (with running status applied), sysex events,
// tempo changes, end of track, and a final "data exhausted" beat for the byte flagged as
// last unless the track has ended. Each result carries its absolute tick position and its
// time in output samples, derived from the current tempo segment as
// sample = segment_sample + floor(dt * sample_rate * tempo / (1000000 * ticks_per_quarter)).
// A byte that produces no event leaves the block idle and ready for another byte. A byte
// that produces an event occupies the block from its acceptance until its last result beat
// has been taken with m_ready, and no other byte is accepted meanwhile; the first beat is
// offered once its time stamp is worked out. The time stamp is worked out on a single
// shared adder, 32 shift-add steps for the multiply and 74 restoring divide steps, and the
// divide by the combined divisor dominates.
// Configuration registers must only be written while no byte is in flight; writing
// initial_tempo also reloads the tempo of the current segment.
module midi_track_event_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mtep_pkg::in_beat_t    s_beat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mtep_pkg::out_beat_t   m_beat,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [23:0]           cfg_wdata
);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_START = 2'd1;
    localparam logic [1:0] T_WAIT  = 2'd2;
    localparam logic [1:0] T_SEND  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [17:0] sample_rate_reg;
    logic [14:0] tpq_reg;

    logic                 step, tempo_wr, main_v, exh_v, st_done;
    mtep_pkg::event_t     main_ev;
    mtep_pkg::seg_info_t  seg;
    logic [31:0]          st_sample;

    // Events of the byte in flight wait here until they are stamped and sent.
    logic                 main_pend_reg, main_pend_next;
    logic                 exh_pend_reg, exh_pend_next;
    mtep_pkg::event_t     ev_reg;
    logic                 m_valid_reg, m_valid_next;
    mtep_pkg::out_beat_t  out_reg, out_next;

    assign s_ready  = (state_reg == T_IDLE);
    assign step     = s_valid && s_ready;
    assign tempo_wr = cfg_we && (cfg_addr == mtep_pkg::CFG_INIT_TEMPO);

    mtep_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .beat          (s_beat),
        .tempo_wr      (tempo_wr),
        .tempo_val     (cfg_wdata),
        .seg_load      (st_done),
        .seg_sample_in (st_sample),
        .main_valid    (main_v),
        .exh_valid     (exh_v),
        .main_event    (main_ev),
        .seg_info      (seg)
    );

    mtep_stamp u_stamp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (state_reg == T_START),
        .seg         (seg),
        .sample_rate (sample_rate_reg),
        .ticks_per_q (tpq_reg),
        .done        (st_done),
        .sample      (st_sample)
    );

    // Sequencer: accept a byte, stamp its events once, then hand out one or two beats.
    always_comb begin
        state_next     = state_reg;
        main_pend_next = main_pend_reg;
        exh_pend_next  = exh_pend_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (step) begin
                    main_pend_next = main_v;
                    exh_pend_next  = exh_v;
                    if (main_v || exh_v) begin
                        state_next = T_START;
                    end
                end
            end
            T_START: begin
                state_next = T_WAIT;
            end
            T_WAIT: begin
                if (st_done) begin
                    out_next.tick_time   = seg.tick_count;
                    out_next.sample_time = st_sample;
                    if (main_pend_reg) begin
                        out_next.event_kind   = ev_reg.kind;
                        out_next.status_byte  = ev_reg.status;
                        out_next.first_data   = ev_reg.d1;
                        out_next.second_data  = ev_reg.d2;
                        out_next.new_tempo    = ev_reg.tempo;
                        out_next.sysex_length = ev_reg.len;
                        out_next.last         = !exh_pend_reg;
                        main_pend_next        = 1'b0;
                    end else begin
                        out_next.event_kind   = mtep_pkg::EV_EXHAUSTED;
                        out_next.status_byte  = '0;
                        out_next.first_data   = '0;
                        out_next.second_data  = '0;
                        out_next.new_tempo    = '0;
                        out_next.sysex_length = '0;
                        out_next.last         = 1'b1;
                        exh_pend_next         = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = T_SEND;
                end
            end
            T_SEND: begin
                if (m_ready) begin
                    if (exh_pend_reg) begin
                        // The exhausted beat shares the tick and sample of the first one.
                        out_next.event_kind   = mtep_pkg::EV_EXHAUSTED;
                        out_next.status_byte  = '0;
                        out_next.first_data   = '0;
                        out_next.second_data  = '0;
                        out_next.new_tempo    = '0;
                        out_next.sysex_length = '0;
                        out_next.last         = 1'b1;
                        exh_pend_next         = 1'b0;
                    end else begin
                        m_valid_next = 1'b0;
                        state_next   = T_IDLE;
                    end
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= T_IDLE;
            main_pend_reg   <= 1'b0;
            exh_pend_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            sample_rate_reg <= mtep_pkg::SAMPLE_RATE_RST;
            tpq_reg         <= mtep_pkg::TPQ_RST;
        end else begin
            state_reg     <= state_next;
            main_pend_reg <= main_pend_next;
            exh_pend_reg  <= exh_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we && cfg_addr == mtep_pkg::CFG_SAMPLE_RATE) begin
                sample_rate_reg <= cfg_wdata[17:0];
            end
            if (cfg_we && cfg_addr == mtep_pkg::CFG_TICKS_PER_Q) begin
                tpq_reg <= cfg_wdata[14:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (step) begin
            ev_reg <= main_ev;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = out_reg;

    // A result beat is never offered while a new byte may be taken.
    a_ready_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result is pending");

    // The stamp unit only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st_done |-> (state_reg == T_WAIT))
        else $error("time stamp finished outside the wait state");

    // A beat not marked last is followed by another beat of the same byte.
    a_not_last_more: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_beat.last) |=> (m_valid && m_beat.last))
        else $error("second beat of a byte missing");

    // The block goes back to idle only after the last beat has been taken.
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_SEND && state_next == T_IDLE) |-> m_beat.last)
        else $error("returned to idle before the last beat");

endmodule
